// ===== rtl/exp_pitch_sine_oscillator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the oscillator core files
// ----------------------------------------------------------------------------
`ifndef EXP_PITCH_SINE_OSCILLATOR_CORE_DEFINES_SVH
`define EXP_PITCH_SINE_OSCILLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EPSOC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EPSOC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/epsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// epsoc_pkg
// Shared types and constants of the exponential-pitch sine oscillator.
// ----------------------------------------------------------------------------
package epsoc_pkg;

	// Configuration register indexes
	localparam logic REG_PITCH_KNOB     = 1'b0;
	localparam logic REG_BASE_INCREMENT = 1'b1;

	// Reset values of the configuration registers
	localparam logic signed [14:0] PITCH_KNOB_RESET     = 15'sd0;
	localparam logic        [27:0] BASE_INCREMENT_RESET = 28'd25480161;

	// Pitch saturates at plus or minus four volts (Q.12)
	localparam logic signed [16:0] PITCH_LIMIT = 17'sd16384;

	// Classified pitch request: whole octaves and fraction of an octave
	typedef struct packed {
		logic [3:0]  oct;
		logic [11:0] frac;
	} epsoc_pitch_t;

endpackage

// ===== rtl/epsoc_queue.sv =====
// ----------------------------------------------------------------------------
// epsoc_queue
// Small synchronous FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`include "exp_pitch_sine_oscillator_core_defines.svh"

module epsoc_queue import epsoc_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`EPSOC_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "queue overfilled")
	`EPSOC_ASSERT_NEXT(a_write_fills, clk, arst_n, do_wr && !do_rd, !empty, "write lost")

endmodule

// ===== rtl/epsoc_front.sv =====
// ----------------------------------------------------------------------------
// epsoc_front
// Adds the knob offset to the pitch CV, clamps to +/-4 V and splits the
// result into whole octaves and octave fraction.
// ----------------------------------------------------------------------------
module epsoc_front import epsoc_pkg::*; (
	input  logic signed [14:0] pitch_knob,
	input  logic signed [15:0] pitch_cv,
	output epsoc_pitch_t       item
);

	logic signed [16:0] sum;
	logic signed [16:0] clamped;
	logic        [15:0] offset;

	// Offset and saturate
	always_comb begin
		sum = 17'(pitch_knob) + 17'(pitch_cv);
		priority if (sum > PITCH_LIMIT) begin
			clamped = PITCH_LIMIT;
		end else if (sum < -PITCH_LIMIT) begin
			clamped = -PITCH_LIMIT;
		end else begin
			clamped = sum;
		end
	end

	// Shift to 0..8 V, then octave and fraction
	assign offset    = 16'(clamped + PITCH_LIMIT);
	assign item.oct  = offset[15:12];
	assign item.frac = offset[11:0];

endmodule

// ===== rtl/epsoc_back.sv =====
// ----------------------------------------------------------------------------
// epsoc_back
// Sequencer that turns a classified pitch into a phase step, advances the
// phase accumulator and looks up the sine sample.
// ----------------------------------------------------------------------------
`include "exp_pitch_sine_oscillator_core_defines.svh"

module epsoc_back import epsoc_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int EXP_TABLE_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic        [27:0] base_increment,
	input  epsoc_pitch_t       item,
	input  logic               item_valid,
	output logic               item_pop,
	input  logic               res_full,
	output logic               res_push,
	output logic signed [15:0] res_data
);

	localparam int EXP_N      = 1 << EXP_TABLE_BITS;
	localparam int FRAC_SHIFT = 12 - EXP_TABLE_BITS;
	localparam int QW         = SINE_TABLE_BITS - 2;
	localparam int QUARTER    = 1 << QW;
	localparam int UP_SHIFT   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int DOWN_SHIFT = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
	localparam int WIDE_W     = PHASE_BITS + 32;
	localparam logic [11:0]          FRAC_MASK   = 12'((1 << FRAC_SHIFT) - 1);
	localparam longint unsigned      LN2_Q30     = 64'd744261118;
	localparam longint unsigned      HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned      Q30_ONE     = 64'd1073741824;

	typedef logic [31:0] exp_rom_t  [EXP_N];
	typedef logic [14:0] sine_rom_t [QUARTER];

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INTERP = 5'b00010,
		ST_SCALE  = 5'b00100,
		ST_ACCUM  = 5'b01000,
		ST_SINE   = 5'b10000
	} state_t;

	// Restoring long division, used only while the tables are built
	function automatic longint unsigned long_div(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(i / 2^EXP_TABLE_BITS) in Q.30, truncating series of e^y
	function automatic logic [31:0] exp_entry(int i);
		longint unsigned iu;
		longint unsigned y;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned kk;
		int              k;
		iu   = i;
		y    = (iu * LN2_Q30) >> EXP_TABLE_BITS;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (k = 1; k <= 20; k++) begin
			kk   = k;
			term = long_div((term * y) >> 30, kk);
			sum  = sum + term;
		end
		return sum[31:0];
	endfunction

	// 20480 * sin(pi/2 * a / QUARTER), rounded half up
	function automatic logic [14:0] sine_entry(int a);
		longint unsigned au;
		longint unsigned theta;
		longint unsigned term;
		longint unsigned kk;
		longint unsigned mag;
		longint          sum;
		int              k;
		au    = a;
		theta = (au * HALF_PI_Q30) >> QW;
		term  = theta;
		sum   = longint'(theta);
		for (k = 1; k <= 12; k++) begin
			kk   = k;
			term = (((term * theta) >> 30) * theta) >> 30;
			term = long_div(term, (2 * kk) * (2 * kk + 1));
			if ((k & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		mag = ($unsigned(sum) * 64'd20480 + (Q30_ONE >> 1)) >> 30;
		return mag[14:0];
	endfunction

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		for (int i = 0; i < EXP_N; i++) begin
			rom[i] = exp_entry(i);
		end
		return rom;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < QUARTER; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

	localparam exp_rom_t    EXP_ROM   = build_exp_rom();
	localparam logic [31:0] EXP_TOP   = exp_entry(EXP_N);
	localparam sine_rom_t   SINE_ROM  = build_sine_rom();
	localparam logic [14:0] SINE_PEAK = sine_entry(QUARTER);

	state_t                     state_q;
	epsoc_pitch_t               item_q;
	logic [31:0]                lo_q;
	logic [31:0]                hi_q;
	logic [31:0]                mant_q;
	logic [59:0]                prod_q;
	logic [PHASE_BITS-1:0]      phase_q;

	logic [EXP_TABLE_BITS-1:0]  j_idx;
	logic [EXP_TABLE_BITS-1:0]  j_next;
	logic [31:0]                hi_val;
	logic [11:0]                r_ext;
	logic [31:0]                diff;
	logic [43:0]                interp;
	logic [5:0]                 shamt;
	logic [31:0]                step32;
	logic [WIDE_W-1:0]          step_wide;
	logic [PHASE_BITS-1:0]      step;
	logic [SINE_TABLE_BITS-1:0] s_idx;
	logic [1:0]                 quad;
	logic [QW:0]                angle;
	logic [14:0]                mag;

	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign res_push = (state_q == ST_SINE) && !res_full;

	// Exp table read straight from the queue head
	assign j_idx  = item.frac[11:FRAC_SHIFT];
	assign j_next = j_idx + 1'b1;
	assign hi_val = (&j_idx) ? EXP_TOP : EXP_ROM[j_next];

	// Linear interpolation between neighbouring entries
	assign r_ext  = item_q.frac & FRAC_MASK;
	assign diff   = hi_q - lo_q;
	assign interp = 44'(diff) * 44'(r_ext);

	// Octave shift and scaling to the accumulator width
	assign shamt     = 6'd34 - {2'b00, item_q.oct};
	assign step32    = 32'(prod_q >> shamt);
	assign step_wide = (WIDE_W'(step32) << UP_SHIFT) >> DOWN_SHIFT;
	assign step      = step_wide[PHASE_BITS-1:0];

	// Quarter-wave sine lookup with quadrant mirroring
	assign s_idx = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign quad  = s_idx[SINE_TABLE_BITS-1 -: 2];
	assign angle = quad[0] ? ((QW+1)'(QUARTER) - {1'b0, s_idx[QW-1:0]})
	                       : {1'b0, s_idx[QW-1:0]};
	assign mag   = angle[QW] ? SINE_PEAK : SINE_ROM[angle[QW-1:0]];
	assign res_data = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_INTERP;
					end
				end
				ST_INTERP: state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_ACCUM;
				ST_ACCUM: begin
					phase_q <= phase_q + step;
					state_q <= ST_SINE;
				end
				ST_SINE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
			lo_q   <= EXP_ROM[j_idx];
			hi_q   <= hi_val;
		end
		if (state_q == ST_INTERP) begin
			mant_q <= lo_q + 32'(interp >> FRAC_SHIFT);
		end
		if (state_q == ST_SCALE) begin
			prod_q <= 60'(base_increment) * 60'(mant_q);
		end
	end

	`EPSOC_ASSERT_NEXT(a_pop_starts, clk, arst_n, item_pop, state_q == ST_INTERP, "pop without start")
	`EPSOC_ASSERT_NEXT(a_stall_hold, clk, arst_n, (state_q == ST_SINE) && res_full, (state_q == ST_SINE) && $stable(phase_q), "stalled result not held")
	`EPSOC_ASSERT_NEXT(a_push_done, clk, arst_n, res_push, state_q == ST_IDLE, "sequencer did not retire")

endmodule

// ===== rtl/exp_pitch_sine_oscillator_core.sv =====
// An accepted push shows (empty low) after the input queue, the back-end
// sequencer (table read, interpolation, scaling multiply, phase add, sine
// lookup) and the result queue; the sequencer finishes one request before taking the next.
// Both queues hold two entries, so push and pop stall independently.
// Reset (arst_n low) empties the queues, clears the phase accumulator and
// loads pitch_knob = 0 and base_increment = 25480161.
// ----------------------------------------------------------------------------
// exp_pitch_sine_oscillator_core
// Volt-per-octave DDS sine oscillator: pitch CV in, 5 V sine sample out.
// ----------------------------------------------------------------------------
module exp_pitch_sine_oscillator_core import epsoc_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int EXP_TABLE_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] pitch_cv,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sine_out,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic        [27:0] wr_data
);

	localparam int ITEM_W = $bits(epsoc_pitch_t);

	logic signed [14:0] pitch_knob_q;
	logic        [27:0] base_increment_q;
	epsoc_pitch_t       front_item;
	logic [ITEM_W-1:0]  mid_data;
	logic               mid_empty;
	logic               mid_pop;
	logic               res_full;
	logic               res_push;
	logic signed [15:0] res_data;
	logic        [15:0] out_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_knob_q     <= PITCH_KNOB_RESET;
			base_increment_q <= BASE_INCREMENT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PITCH_KNOB:     pitch_knob_q     <= $signed(wr_data[14:0]);
				REG_BASE_INCREMENT: base_increment_q <= wr_data;
				default:            ;
			endcase
		end
	end

	// Front end: offset, clamp, classify
	epsoc_front u_front (
		.pitch_knob (pitch_knob_q),
		.pitch_cv   (pitch_cv),
		.item       (front_item)
	);

	// Queue between front and back
	epsoc_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid_data),
		.empty   (mid_empty)
	);

	// Back end: exp2, phase accumulation, sine lookup
	epsoc_back #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.EXP_TABLE_BITS  (EXP_TABLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.base_increment (base_increment_q),
		.item           (epsoc_pitch_t'(mid_data)),
		.item_valid     (!mid_empty),
		.item_pop       (mid_pop),
		.res_full       (res_full),
		.res_push       (res_push),
		.res_data       (res_data)
	);

	// Result queue
	epsoc_queue #(
		.WIDTH (16),
		.DEPTH (2)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_data),
		.empty   (empty)
	);

	assign sine_out = $signed(out_data);

endmodule
